// ===== design/gbr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants of the Gaussian blur block
// Pixel and side-band types, register codes, reset values of the registers.
// ----------------------------------------------------------------------------
package gbr_pkg;

  localparam int PIX_W         = 32;
  localparam int CH_W          = 8;
  localparam int NUM_CH        = 3;
  localparam int GEOM_W        = 13;
  localparam int WEIGHT_W      = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_W        = 32;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_W         = 12;
  localparam int RADIUS_DEF    = 2;
  localparam int MAX_WIDTH_DEF = 4096;

  localparam int WIDTH_RST   = 640;
  localparam int HEIGHT_RST  = 480;
  localparam int WEIGHT0_RST = 26386;
  localparam int WEIGHT1_RST = 16004;
  localparam int WEIGHT2_RST = 3571;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_WEIGHT0 = 3'd2,
    REG_WEIGHT1 = 3'd3,
    REG_WEIGHT2 = 3'd4,
    REG_WEIGHT3 = 3'd5,
    REG_WEIGHT4 = 3'd6,
    REG_WEIGHT5 = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_e;

  // Side-band that travels with a result through the kernel pipeline
  typedef struct packed {
    logic interior;
    logic last;
    pix_t raw;
  } side_t;

  // Reset value of the 1D weight at a given distance
  function automatic logic [WEIGHT_W-1:0] weight_rst(input int unsigned distance);
    logic [WEIGHT_W-1:0] val;
    case (distance)
      0:       val = WEIGHT_W'(WEIGHT0_RST);
      1:       val = WEIGHT_W'(WEIGHT1_RST);
      2:       val = WEIGHT_W'(WEIGHT2_RST);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== design/gbr_line_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_line_mem: line store of the blur window
// One word per column, holding the last rows seen at that column.
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gbr_line_mem #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 128,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/gbr_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_filter: separable kernel multiply-accumulate
// Stage A forms weighted column sums, stage B the weighted sum across columns.
// ----------------------------------------------------------------------------
module gbr_filter import gbr_pkg::*; #(
  parameter int RADIUS = RADIUS_DEF,
  localparam int KT    = 2 * RADIUS + 1,
  localparam int VW    = CH_W + WEIGHT_W + $clog2(KT),
  localparam int HW    = VW + WEIGHT_W + $clog2(KT)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pix_t                win_i [KT][KT],
  input  wire logic [WEIGHT_W-1:0] wt_i [RADIUS+1],
  input  wire side_t               side_i,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [HW-1:0]       sum_o [NUM_CH],
  output side_t                    side_o
);

  function automatic int tap_dist(input int k);
    return (k < RADIUS) ? (RADIUS - k) : (k - RADIUS);
  endfunction

  logic          va_v_r;
  side_t         va_side_r;
  logic [VW-1:0] vsum_r [NUM_CH][KT];
  logic [VW-1:0] vsum_c [NUM_CH][KT];
  logic          vb_v_r;
  side_t         vb_side_r;
  logic [HW-1:0] hsum_r [NUM_CH];
  logic [HW-1:0] hsum_c [NUM_CH];
  logic          rdy_a;
  logic          rdy_b;
  logic          mv_a;

  // Advance a stage when the next one is empty or moving
  assign rdy_b    = !vb_v_r || out_ready;
  assign mv_a     = va_v_r && rdy_b;
  assign rdy_a    = !va_v_r || rdy_b;
  assign in_ready = rdy_a;

  // Weighted column sums over the window rows
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int j = 0; j < KT; j++) begin
        vsum_c[c][j] = '0;
        for (int k = 0; k < KT; k++) begin
          vsum_c[c][j] = vsum_c[c][j]
                       + VW'(win_i[k][j][c*CH_W +: CH_W]) * VW'(wt_i[tap_dist(k)]);
        end
      end
    end
  end

  // Weighted sum across the column sums
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      hsum_c[c] = '0;
      for (int j = 0; j < KT; j++) begin
        hsum_c[c] = hsum_c[c] + HW'(vsum_r[c][j]) * HW'(wt_i[tap_dist(j)]);
      end
    end
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_v_r <= 1'b0;
      vb_v_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_v_r <= in_valid;
      end
      if (rdy_b) begin
        vb_v_r <= va_v_r;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_valid && rdy_a) begin
      vsum_r    <= vsum_c;
      va_side_r <= side_i;
    end
    if (mv_a) begin
      hsum_r    <= hsum_c;
      vb_side_r <= va_side_r;
    end
  end

  assign out_valid = vb_v_r;
  assign sum_o     = hsum_r;
  assign side_o    = vb_side_r;

endmodule
`default_nettype wire

// ===== design/gaussian_blur_rgb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_blur_rgb: streaming Gaussian blur of ARGB pixels
// Square separable kernel over R, G and B; frame border passes through.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready transactions; in_action selects a pixel or a drain
//           tick. A pixel transaction produces a result once RADIUS rows plus
//           RADIUS pixels are pending; a drain tick flushes one pending pixel
//           only after a whole frame has arrived, and is dropped otherwise.
//   out_* : valid/ready transactions in raster order; out_frame_last marks
//           the final pixel of a frame.
//   cfg_* : register writes, always ready; the user writes them only while
//           the block is idle, and the block does not enforce it. Writing
//           width or height restarts the stream and drops pending data.
// Throughput: one transaction per cycle on both sides while out_ready is high.
// Pipeline: the accepting edge loads the line memory read, then window load,
//   column MAC stage, row MAC stage and output register follow in order.
// Reset: counters cleared, registers to defaults; line memory is not cleared.
// Stall: while out_ready is low the result holds in the output register and
//   the stages behind it keep filling; in_ready drops once all are full.
// ----------------------------------------------------------------------------
module gaussian_blur_rgb import gbr_pkg::*; #(
  parameter int RADIUS    = RADIUS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_action,
  input  wire logic [PIX_W-1:0]     in_pixel_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [PIX_W-1:0]     out_pixel_out,
  output logic                      out_frame_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WEIGHT_W-1:0]  cfg_data
);

  localparam int KT    = 2 * RADIUS + 1;
  localparam int NSLOT = 2 * RADIUS;
  localparam int LW    = NSLOT * PIX_W;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = $clog2(RADIUS * MAX_WIDTH + RADIUS + 2);
  localparam int DW    = $clog2(2 * RADIUS + 2);
  localparam int SW    = $clog2(NSLOT);
  localparam int VW    = CH_W + WEIGHT_W + $clog2(KT);
  localparam int HW    = VW + WEIGHT_W + $clog2(KT);

  // Registers
  logic [GEOM_W-1:0]   width_r;
  logic [GEOM_W-1:0]   height_r;
  logic [WEIGHT_W-1:0] wt_r [RADIUS+1];
  logic                cfg_wr;
  logic                restart;
  logic [EW-1:0]       eff_w;
  logic [GEOM_W-1:0]   eff_h;

  // Stream position
  logic [CW-1:0]    in_col_r,  in_col_nxt;
  logic [ROW_W-1:0] in_row_r,  in_row_nxt;
  logic [CW-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [PW-1:0]    pending_r, pending_nxt;
  logic [DW-1:0]    rowdiff_r, rowdiff_nxt;

  logic              is_pix;
  logic              acc;
  logic              emit;
  logic              load1;
  logic [PW-1:0]     pend_p1;
  logic [PW-1:0]     thresh;
  logic [EW-1:0]     in_col_p1;
  logic [EW-1:0]     out_col_p1;
  logic [GEOM_W-1:0] in_row_p1;
  logic [GEOM_W-1:0] out_row_p1;
  logic              in_wrap;
  logic              in_row_wrap;
  logic              out_wrap;
  logic              out_row_wrap;
  logic              interior;
  logic [CW-1:0]     rd_addr;

  // Stage 1: line memory read
  logic          s1_v_r;
  logic          s1_pix_r;
  logic          s1_emit_r;
  logic [CW-1:0] s1_addr_r;
  pix_t          s1_pixel_r;
  logic          s1_interior_r;
  logic          s1_last_r;
  logic [SW-1:0] s1_lag_r;
  logic          fwd_r;
  logic [LW-1:0] fwd_data_r;
  logic [LW-1:0] lb_rd;
  logic [LW-1:0] col1;
  logic [LW-1:0] wr_word;
  logic          lb_we;
  logic          mv1;
  logic          rdy1;

  // Stage 2: window
  pix_t  win_r [KT][KT];
  pix_t  col_in [KT];
  logic  s2_v_r;
  logic  s2_pix_r;
  side_t s2_side_r;
  side_t f_side;
  logic  rdy2;
  logic  f_in_ready;

  // Kernel pipeline and output register
  logic          f_v;
  logic [HW-1:0] f_sum [NUM_CH];
  side_t         f_side_o;
  logic          rdy_out;
  logic          out_v_r;
  pix_t          out_pix_r;
  logic          out_last_r;
  pix_t          blur_pix;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= GEOM_W'(WIDTH_RST);
      height_r <= GEOM_W'(HEIGHT_RST);
      for (int d = 0; d <= RADIUS; d++) begin
        wt_r[d] <= weight_rst(d);
      end
    end else if (cfg_wr) begin
      if (cfg_index == REG_WIDTH) begin
        width_r <= cfg_data[GEOM_W-1:0];
      end
      if (cfg_index == REG_HEIGHT) begin
        height_r <= cfg_data[GEOM_W-1:0];
      end
      for (int d = 0; d <= RADIUS; d++) begin
        if (cfg_index == CFG_IDX_W'(REG_WEIGHT0) + CFG_IDX_W'(d)) begin
          wt_r[d] <= cfg_data;
        end
      end
    end
  end

  // Clamp geometry to the supported range
  always_comb begin
    if (width_r == '0) begin
      eff_w = EW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = GEOM_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = GEOM_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  // --------------------------------------------------------------------------
  // Accept and schedule
  // --------------------------------------------------------------------------
  always_comb begin
    is_pix       = action_e'(in_action) == ACT_PIXEL;
    acc          = in_valid && in_ready;
    pend_p1      = pending_r + PW'(1);
    thresh       = PW'(eff_w) * PW'(RADIUS) + PW'(RADIUS);
    if (is_pix) begin
      emit = pend_p1 > thresh;
    end else begin
      emit = (in_col_r == '0) && (in_row_r == '0) && (pending_r != '0);
    end
    load1        = acc && (is_pix || emit);

    in_col_p1    = EW'(in_col_r) + EW'(1);
    in_wrap      = in_col_p1 >= eff_w;
    in_row_p1    = GEOM_W'(in_row_r) + GEOM_W'(1);
    in_row_wrap  = in_row_p1 >= eff_h;
    out_col_p1   = EW'(out_col_r) + EW'(1);
    out_wrap     = out_col_p1 >= eff_w;
    out_row_p1   = GEOM_W'(out_row_r) + GEOM_W'(1);
    out_row_wrap = out_row_p1 >= eff_h;

    interior = (out_row_r >= ROW_W'(RADIUS))
            && (GEOM_W'(out_row_r) + GEOM_W'(RADIUS) < eff_h)
            && (out_col_r >= CW'(RADIUS))
            && (EW'(out_col_r) + EW'(RADIUS) < eff_w);

    rd_addr = is_pix ? in_col_r : out_col_r;
  end

  // Next position, pending count and row distance
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (acc && is_pix) begin
      in_col_nxt = in_wrap ? '0 : CW'(in_col_p1);
      if (in_wrap) begin
        in_row_nxt = in_row_wrap ? '0 : ROW_W'(in_row_p1);
      end
    end
    if (acc && emit) begin
      out_col_nxt = out_wrap ? '0 : CW'(out_col_p1);
      if (out_wrap) begin
        out_row_nxt = out_row_wrap ? '0 : ROW_W'(out_row_p1);
      end
    end
    pending_nxt = pending_r + PW'(acc && is_pix) - PW'(acc && emit);
    rowdiff_nxt = rowdiff_r + DW'(acc && is_pix && in_wrap)
                            - DW'(acc && emit && out_wrap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pending_r <= '0;
      rowdiff_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pending_r <= pending_nxt;
      rowdiff_r <= rowdiff_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: read the column word, write it back shifted by one row
  // --------------------------------------------------------------------------
  assign rdy2 = !s2_v_r || f_in_ready;
  assign mv1  = s1_v_r && rdy2;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  assign col1    = fwd_r ? fwd_data_r : lb_rd;
  assign wr_word = {col1[LW-PIX_W-1:0], s1_pixel_r};
  assign lb_we   = mv1 && s1_pix_r;

  gbr_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (LW)
  ) u_line_mem (
    .clk   (clk),
    .we    (lb_we),
    .waddr (s1_addr_r),
    .wdata (wr_word),
    .re    (load1),
    .raddr (rd_addr),
    .rdata (lb_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= load1;
    end
  end

  // Hold the transaction and forward a write that lands on the read column
  always_ff @(posedge clk) begin
    if (load1) begin
      s1_pix_r      <= is_pix;
      s1_emit_r     <= emit;
      s1_addr_r     <= rd_addr;
      s1_pixel_r    <= in_pixel_in;
      s1_interior_r <= interior;
      s1_last_r     <= out_wrap && out_row_wrap;
      s1_lag_r      <= SW'(rowdiff_r - DW'(1));
      fwd_r         <= lb_we && (s1_addr_r == rd_addr);
      fwd_data_r    <= wr_word;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: shift the new column into the window
  // --------------------------------------------------------------------------
  always_comb begin
    col_in[0] = s1_pixel_r;
    for (int k = 1; k < KT; k++) begin
      col_in[k] = col1[(k-1)*PIX_W +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      for (int k = 0; k < KT; k++) begin
        win_r[k][0] <= col_in[k];
        for (int j = 1; j < KT; j++) begin
          win_r[k][j] <= win_r[k][j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= mv1 && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_pix_r           <= s1_pix_r;
      s2_side_r.interior <= s1_interior_r;
      s2_side_r.last     <= s1_last_r;
      s2_side_r.raw      <= col1[PIX_W*s1_lag_r +: PIX_W];
    end
  end

  // Pixel transactions take the window center, drain ticks the stored pixel
  always_comb begin
    f_side     = s2_side_r;
    f_side.raw = s2_pix_r ? win_r[RADIUS][RADIUS] : s2_side_r.raw;
  end

  gbr_filter #(
    .RADIUS (RADIUS)
  ) u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_ready  (f_in_ready),
    .win_i     (win_r),
    .wt_i      (wt_r),
    .side_i    (f_side),
    .out_valid (f_v),
    .out_ready (rdy_out),
    .sum_o     (f_sum),
    .side_o    (f_side_o)
  );

  // --------------------------------------------------------------------------
  // Output register: truncate, saturate, pick blurred or raw pixel
  // --------------------------------------------------------------------------
  always_comb begin
    blur_pix = '1;
    for (int c = 0; c < NUM_CH; c++) begin
      if (|f_sum[c][HW-1:FRAC_W+CH_W]) begin
        blur_pix[c*CH_W +: CH_W] = '1;
      end else begin
        blur_pix[c*CH_W +: CH_W] = f_sum[c][FRAC_W +: CH_W];
      end
    end
  end

  assign rdy_out = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_out) begin
      out_v_r <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (f_v && rdy_out) begin
      out_pix_r  <= f_side_o.interior ? blur_pix : f_side_o.raw;
      out_last_r <= f_side_o.last;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= thresh)
    else $error("pending count above window depth");

  a_drain_border: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_pix_r) |-> !s2_side_r.interior)
    else $error("drained pixel lies inside the blur area");

  a_rowdiff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rowdiff_r <= DW'(2 * RADIUS + 1))
    else $error("row distance beyond line store depth");

  a_drain_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (load1 && !is_pix) |-> (rowdiff_r != '0))
    else $error("drain tick with no stored row");

endmodule
`default_nettype wire
